@@ sv/ssu_pkg.sv @@
`default_nettype none

package ssu_pkg;

    localparam int VALUE_W = 32;

    // Word taken on the input channel
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last_item;
    } t_in_word;

    // Word given on the output channel
    typedef struct packed {
        logic signed [VALUE_W-1:0] result_value;
        logic                      last_result;
        logic                      overflow;
    } t_out_word;

    // Controls broadcast from the sequencer to every cell
    typedef struct packed {
        logic cmp;   // compare the incoming value against the held one
        logic ins;   // insert: keep, take the new value, or take the left neighbour's
        logic shl;   // emit: take the right neighbour's contents
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ sv/ssu_cell.sv @@
`default_nettype none

module ssu_cell import ssu_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_cell_ctl                 i_ctl,
    input  wire logic signed [VALUE_W-1:0] i_cmp_val,
    input  wire logic signed [VALUE_W-1:0] i_ins_val,
    input  wire logic signed [VALUE_W-1:0] i_prev_val,
    input  wire logic                      i_prev_hold,
    input  wire logic                      i_prev_lt,
    input  wire logic signed [VALUE_W-1:0] i_next_val,
    input  wire logic                      i_next_hold,
    output      logic signed [VALUE_W-1:0] o_val,
    output      logic                      o_hold,
    output      logic                      o_lt,
    output      logic                      o_eq
);

    logic signed [VALUE_W-1:0] r_val;
    logic                      r_hold;
    logic                      r_lt;
    logic                      r_eq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= 1'b0;
            r_lt   <= 1'b0;
            r_eq   <= 1'b0;
        end else begin
            if (i_ctl.cmp) begin
                r_lt <= r_hold && (r_val < i_cmp_val);
                r_eq <= r_hold && (r_val == i_cmp_val);
            end
            if (i_ctl.ins) begin
                // hold if smaller; first cell not smaller takes the new value; the rest shift up
                if (!r_lt) begin
                    if (i_prev_lt) begin
                        r_val  <= i_ins_val;
                        r_hold <= 1'b1;
                    end else begin
                        r_val  <= i_prev_val;
                        r_hold <= i_prev_hold;
                    end
                end
            end else if (i_ctl.shl) begin
                r_val  <= i_next_val;
                r_hold <= i_next_hold;
                r_eq   <= 1'b0;
            end
        end
    end

    assign o_val  = r_val;
    assign o_hold = r_hold;
    assign o_lt   = r_lt;
    assign o_eq   = r_eq;

endmodule

`default_nettype wire

@@ sv/sorted_set_union_unit.sv @@
`default_nettype none

// Channel   Direction  Handshake               Word
// input     in         i_in_valid/o_in_stall   t_in_word  (value, last_item)
// output    out        o_out_valid/i_out_stall t_out_word (result_value, last_result, overflow)
//
// Each input word is compared against every cell of the row as it is accepted, then inserted
// in state S_INS (cells hold, take the new value or take their left neighbour's).
// After a word marked last_item, the row drains from cell 0, one word per cycle while the
// output is not stalled; input is held off until the final word sits in the output register.
// Reset (i_rst_n low, synchronous) empties the row and clears the overflow flag.
// A stalled output word holds; while the final one waits, the next input word is taken.

module sorted_set_union_unit import ssu_pkg::*; #(
    parameter int MAX_ITEMS = 64
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output      logic      o_in_stall,
    input  wire t_in_word  i_in,
    output      logic      o_out_valid,
    input  wire logic      i_out_stall,
    output      t_out_word o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_EMIT
    } t_state;

    t_state                    r_state;
    logic signed [VALUE_W-1:0] r_x;
    logic                      r_last;
    logic                      r_dropped;
    logic                      r_out_valid;
    t_out_word                 r_out;

    logic signed [VALUE_W-1:0] w_val [MAX_ITEMS];
    logic [MAX_ITEMS-1:0]      w_hold;
    logic [MAX_ITEMS-1:0]      w_lt;
    logic [MAX_ITEMS-1:0]      w_eq;
    logic                      w_dup;
    logic                      w_full;
    logic                      w_accept;
    logic                      w_load;
    t_cell_ctl                 w_ctl;

    // Duplicate anywhere in the row, or the last cell occupied
    assign w_dup    = |w_eq;
    assign w_full   = w_hold[MAX_ITEMS-1];
    assign w_accept = i_in_valid && (r_state == S_IDLE);
    assign w_load   = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);

    assign w_ctl.cmp = w_accept;
    assign w_ctl.ins = (r_state == S_INS) && !w_dup && !w_full;
    assign w_ctl.shl = w_load;

    genvar g;
    generate
        for (g = 0; g < MAX_ITEMS; g++) begin : g_cell
            logic signed [VALUE_W-1:0] w_prev_val;
            logic                      w_prev_hold;
            logic                      w_prev_lt;
            logic signed [VALUE_W-1:0] w_next_val;
            logic                      w_next_hold;

            if (g == 0) begin : g_head
                // Cell 0 always sees "left neighbour smaller": take the value if not lt
                assign w_prev_val  = r_x;
                assign w_prev_hold = 1'b0;
                assign w_prev_lt   = 1'b1;
            end else begin : g_body
                assign w_prev_val  = w_val[g-1];
                assign w_prev_hold = w_hold[g-1];
                assign w_prev_lt   = w_lt[g-1];
            end

            if (g == MAX_ITEMS - 1) begin : g_tail
                assign w_next_val  = w_val[g];
                assign w_next_hold = 1'b0;
            end else begin : g_mid
                assign w_next_val  = w_val[g+1];
                assign w_next_hold = w_hold[g+1];
            end

            ssu_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_ctl),
                .i_cmp_val   (i_in.value),
                .i_ins_val   (r_x),
                .i_prev_val  (w_prev_val),
                .i_prev_hold (w_prev_hold),
                .i_prev_lt   (w_prev_lt),
                .i_next_val  (w_next_val),
                .i_next_hold (w_next_hold),
                .o_val       (w_val[g]),
                .o_hold      (w_hold[g]),
                .o_lt        (w_lt[g]),
                .o_eq        (w_eq[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Hold the output word while stalled, drop it once taken; a fresh load sets it
            r_out_valid <= w_load || (r_out_valid && i_out_stall);
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_x     <= i_in.value;
                        r_last  <= i_in.last_item;
                        r_state <= S_INS;
                    end
                end
                S_INS: begin
                    // A new distinct value with no room left is dropped and flagged
                    if (!w_dup && w_full) begin
                        r_dropped <= 1'b1;
                    end
                    r_state <= r_last ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (w_load) begin
                        r_out.result_value <= w_val[0];
                        r_out.last_result  <= !w_hold[1];
                        r_out.overflow     <= r_dropped;
                        if (!w_hold[1]) begin
                            r_dropped <= 1'b0;
                            r_state   <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Occupied cells always form an unbroken run from cell 0
    a_hold_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_hold & (w_hold + MAX_ITEMS'(1))) == '0)
        else $error("occupied cells are not contiguous from cell 0");

    // Draining only ever happens with something in cell 0
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> w_hold[0])
        else $error("emitting from an empty row");

    // An accepted word moves the sequencer to S_INS on the following cycle
    a_accept_ins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_INS))
        else $error("accepted word not followed by insertion");

    // After the final word of a union the row is empty and the flag cleared
    a_final_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && !w_hold[1]) |=> (!w_hold[0] && !r_dropped && r_out.last_result))
        else $error("row or overflow flag not cleared after final word");

endmodule

`default_nettype wire
